// ===== src/cth_pkg.sv =====
// ----------------------------------------------------------------------------
// Chain time histogram package
// Shared payload types and constants of the chain time histogram block.
// ----------------------------------------------------------------------------
package cth_pkg;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    localparam logic [31:0] RUNS_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] TSUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] BSUM_MAX = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [63:0] chain_pc;
        logic [31:0] wall_us;
        logic [15:0] chain_length;
    } cth_in_t;

    typedef struct packed {
        logic [63:0] entry_pc;
        logic [31:0] run_count;
        logic [47:0] time_total;
        logic [31:0] time_peak;
        logic [39:0] blocks_total;
        logic        entry_valid;
        logic        last;
    } cth_out_t;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] runs;
        logic [47:0] tsum;
        logic [31:0] tmax;
        logic [39:0] bsum;
    } cth_entry_t;

endpackage

// ===== src/cth_rank.sv =====
// ----------------------------------------------------------------------------
// Chain time histogram ranking
// Keeps the top entries by time sum; earlier entries win ties.
// ----------------------------------------------------------------------------
module cth_rank #(
    parameter int TOP_COUNT = 8
) (
    input  logic                              aclk,
    input  logic                              clear,
    input  logic                              ins_en,
    input  cth_pkg::cth_entry_t               ins_entry,
    input  logic [$clog2(TOP_COUNT+1)-1:0]    rd_idx,
    output cth_pkg::cth_entry_t               rd_entry,
    output logic                              rd_last
);
    import cth_pkg::*;

    localparam int RW = $clog2(TOP_COUNT+1);

    cth_entry_t rank_reg [TOP_COUNT];
    cth_entry_t prev_entry [TOP_COUNT];
    logic [TOP_COUNT-1:0] gt;
    logic [TOP_COUNT:0]   gt_prev;

    always_comb begin
        for (int j = 0; j < TOP_COUNT; j++) begin
            gt[j] = ins_entry.tsum > rank_reg[j].tsum;
        end
        gt_prev = {gt, 1'b0};
        prev_entry[0] = ins_entry;
        for (int j = 1; j < TOP_COUNT; j++) begin
            prev_entry[j] = rank_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            for (int j = 0; j < TOP_COUNT; j++) begin
                rank_reg[j] <= '0;
            end
        end else if (ins_en && ins_entry.tsum != '0) begin
            for (int j = 0; j < TOP_COUNT; j++) begin
                if (gt[j]) begin
                    rank_reg[j] <= gt_prev[j] ? prev_entry[j] : ins_entry;
                end
            end
        end
    end

    always_comb begin
        rd_entry = '0;
        rd_last  = 1'b1;
        for (int j = 0; j < TOP_COUNT; j++) begin
            if (rd_idx == RW'(j)) begin
                rd_entry = rank_reg[j];
            end
        end
        for (int j = 1; j < TOP_COUNT; j++) begin
            if (rd_idx == RW'(j-1)) begin
                rd_last = (rank_reg[j].tsum == '0);
            end
        end
    end

endmodule

// ===== src/chain_time_histogram_top_n.sv =====
// ----------------------------------------------------------------------------
// Chain time histogram top N
// Hash histogram of chain samples with a ranked drain.
// ----------------------------------------------------------------------------
// The s_ channel takes one transfer per item: action 0 records a sample,
// action 1 drains the table. A record hashes the key, reads one slot per
// probe from the slot memory (states PRD, then PCMP: read, then compare)
// and writes the updated slot back once a probe finds its key or an empty
// slot; after TABLE_DEPTH probes without one the sample is dropped. s_ready
// stays low from a record's transfer until the record is done. A record
// with a zero key or a zero time is taken and ignored. A drain walks all
// TABLE_DEPTH slots (DRD, then DCMP per slot), clearing each and feeding
// the ranking, then presents up to TOP_COUNT results on the m_ channel,
// one per cycle while m_ready is high; the final one carries last. An empty
// drain gives one result with entry_valid low. The output register holds a
// result while m_ready is low and emission waits for it. Items are taken
// one at a time. After reset a clearing pass writes every key to zero, with s_ready low.
// ----------------------------------------------------------------------------
module chain_time_histogram_top_n #(
    parameter int TABLE_DEPTH = 4096,
    parameter int TOP_COUNT   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cth_pkg::cth_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cth_pkg::cth_out_t    m_data
);
    import cth_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = $clog2(TOP_COUNT+1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PRD   = 3'd2;
    localparam logic [2:0] ST_PCMP  = 3'd3;
    localparam logic [2:0] ST_DRD   = 3'd4;
    localparam logic [2:0] ST_DCMP  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    cth_entry_t mem [TABLE_DEPTH];
    cth_entry_t rd_q;
    logic       we;
    logic [AW-1:0] waddr;
    cth_entry_t wdata;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    cth_in_t       item_reg;
    logic [RW-1:0] ridx_reg, ridx_next;
    logic          m_valid_reg;
    cth_out_t      m_data_reg;

    logic          rk_clear, rk_ins;
    cth_entry_t    rk_rd;
    logic          rk_last;

    logic [63:0] k;
    logic [63:0] h;
    assign k = s_data.chain_pc;
    assign h = (k >> 4) ^ (k >> 16) ^ (k >> 28);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[addr_next];
    end

    cth_rank #(.TOP_COUNT(TOP_COUNT)) u_rank (
        .aclk      (aclk),
        .clear     (rk_clear),
        .ins_en    (rk_ins),
        .ins_entry (rd_q),
        .rd_idx    (ridx_reg),
        .rd_entry  (rk_rd),
        .rd_last   (rk_last)
    );

    logic [32:0] runs_s;
    logic [48:0] tsum_s;
    logic [40:0] bsum_s;
    cth_entry_t  upd;

    always_comb begin
        runs_s = {1'b0, rd_q.runs} + 33'd1;
        tsum_s = {1'b0, rd_q.tsum} + {17'd0, item_reg.wall_us};
        bsum_s = {1'b0, rd_q.bsum} + {25'd0, item_reg.chain_length};
        upd.key  = item_reg.chain_pc;
        upd.runs = runs_s[32] ? RUNS_MAX : runs_s[31:0];
        upd.tsum = tsum_s[48] ? TSUM_MAX : tsum_s[47:0];
        upd.bsum = bsum_s[40] ? BSUM_MAX : bsum_s[39:0];
        upd.tmax = (item_reg.wall_us > rd_q.tmax) ? item_reg.wall_us : rd_q.tmax;
        if (rd_q.key == '0) begin
            upd.runs = 32'd1;
            upd.tsum = {16'd0, item_reg.wall_us};
            upd.tmax = item_reg.wall_us;
            upd.bsum = {24'd0, item_reg.chain_length};
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        we           = 1'b0;
        waddr        = addr_reg;
        wdata        = '0;
        rk_clear     = 1'b0;
        rk_ins       = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(TABLE_DEPTH-1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next = '0;
                    if (s_data.action == ACT_DRAIN) begin
                        addr_next = '0;
                        rk_clear  = 1'b1;
                        state_next = ST_DRD;
                    end else if (s_data.chain_pc != '0 && s_data.wall_us != '0) begin
                        addr_next = h[AW-1:0];
                        state_next = ST_PRD;
                    end
                end
            end
            ST_PRD: begin
                state_next = ST_PCMP;
            end
            ST_PCMP: begin
                if (rd_q.key == item_reg.chain_pc || rd_q.key == '0) begin
                    we = 1'b1;
                    wdata = upd;
                    state_next = ST_IDLE;
                end else if (cnt_reg == (AW+1)'(TABLE_DEPTH-1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                    state_next = ST_PRD;
                end
            end
            ST_DRD: begin
                state_next = ST_DCMP;
            end
            ST_DCMP: begin
                if (rd_q.key != '0) begin
                    we = 1'b1;
                    rk_ins = 1'b1;
                end
                if (addr_reg == AW'(TABLE_DEPTH-1)) begin
                    ridx_next = '0;
                    state_next = ST_EMIT;
                end else begin
                    addr_next = addr_reg + 1'b1;
                    state_next = ST_DRD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ridx_next = ridx_reg + 1'b1;
                    if (rk_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            ridx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            ridx_reg    <= ridx_next;
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.entry_pc     <= rk_rd.key;
            m_data_reg.run_count    <= rk_rd.runs;
            m_data_reg.time_total   <= rk_rd.tsum;
            m_data_reg.time_peak    <= rk_rd.tmax;
            m_data_reg.blocks_total <= rk_rd.bsum;
            m_data_reg.entry_valid  <= (rk_rd.tsum != '0);
            m_data_reg.last         <= rk_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    property p_no_accept_in_clear;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready;
    endproperty
    a_no_accept_in_clear: assert property (p_no_accept_in_clear)
        else $error("input accepted during clearing pass");

    property p_last_has_valid_or_empty;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.entry_valid) |-> m_data.last;
    endproperty
    a_last_empty: assert property (p_last_has_valid_or_empty)
        else $error("empty result without last");

endmodule
